/* rtl/midi_note_duration_tracker_defines.svh */
// assertion macros for the note duration tracker
// both sample on the rising edge of clk_i and are off while rst_ni is low
`ifndef MIDI_NOTE_DURATION_TRACKER_DEFINES_SVH
`define MIDI_NOTE_DURATION_TRACKER_DEFINES_SVH

// same-cycle implication
`define MNDT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MNDT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mndt_pkg.sv */
`timescale 1ns / 1ps

package mndt_pkg;

  // field widths
  localparam int unsigned ModeW   = 3;
  localparam int unsigned KindW   = 3;
  localparam int unsigned KeyW    = 7;
  localparam int unsigned VelW    = 7;
  localparam int unsigned TimeW   = 31;
  localparam int unsigned ClkW    = 32;
  localparam int unsigned DataW   = 14;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 31;

  // queue between front and back
  localparam int unsigned QueueDepth = 2;

  // message kinds
  localparam logic [ModeW-1:0] MODE_NOTE_ON  = 3'd0;
  localparam logic [ModeW-1:0] MODE_NOTE_OFF = 3'd1;
  localparam logic [ModeW-1:0] MODE_BEND     = 3'd2;
  localparam logic [ModeW-1:0] MODE_TOUCH    = 3'd3;
  localparam logic [ModeW-1:0] MODE_CONTROL  = 3'd4;

  // result kinds
  localparam logic [KindW-1:0] KIND_APPENDED  = 3'd0;
  localparam logic [KindW-1:0] KIND_HELD      = 3'd1;
  localparam logic [KindW-1:0] KIND_MATCHED   = 3'd2;
  localparam logic [KindW-1:0] KIND_UNMATCHED = 3'd3;
  localparam logic [KindW-1:0] KIND_FULL      = 3'd4;
  localparam logic [KindW-1:0] KIND_DRUM_OFF  = 3'd5;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_PERC_MODE    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RECORD_MERGE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PUNCH_IN     = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_LOOP_ADJUST  = 2'd3;

  // work the back end has to do for an item
  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_PASS
  } op_e;

  typedef struct packed {
    logic             perc_mode;
    logic             record_merge;
    logic             punch_in_enable;
    logic [TimeW-1:0] loop_adjust;
  } cfg_t;

  typedef struct packed {
    op_e              op;
    logic [KindW-1:0] kind;
    logic [KeyW-1:0]  key;
    logic [TimeW-1:0] now_time;
    logic [ClkW-1:0]  event_clock;
    logic [DataW-1:0] data_value;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

/* rtl/mndt_front.sv */
`timescale 1ns / 1ps

module mndt_front
  import mndt_pkg::*;
(
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ModeW-1:0] mode_i,
  input  logic [KeyW-1:0]  key_i,
  input  logic [VelW-1:0]  velocity_i,
  input  logic [TimeW-1:0] now_time_i,
  input  cfg_t             cfg_i,
  input  q_stat_t          q_stat_i,
  output logic             push_o,
  output item_t            item_o
);

  // take items while the queue has room
  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  // classify the message and build the fields that need no stack
  always_comb begin
    item_o             = '0;
    item_o.op          = OP_PASS;
    item_o.kind        = KIND_APPENDED;
    item_o.key         = key_i;
    item_o.now_time    = now_time_i;
    item_o.event_clock = {1'b0, now_time_i} - {1'b0, cfg_i.loop_adjust};
    unique case (mode_i)
      MODE_NOTE_ON, MODE_NOTE_OFF: begin
        item_o.data_value = {7'd0, velocity_i};
        if (mode_i == MODE_NOTE_ON && velocity_i != '0) begin
          // held note-on, or a plain append in drum mode
          item_o.op = cfg_i.perc_mode ? OP_PASS : OP_PUSH;
        end else if (cfg_i.perc_mode) begin
          item_o.kind = KIND_DRUM_OFF;
        end else begin
          item_o.op   = OP_POP;
          item_o.kind = KIND_UNMATCHED;
        end
      end
      MODE_BEND:    item_o.data_value = {velocity_i, key_i};
      MODE_TOUCH:   item_o.data_value = {7'd0, key_i};
      MODE_CONTROL: item_o.data_value = {7'd0, velocity_i};
      default:      item_o.data_value = '0;
    endcase
  end

endmodule

/* rtl/mndt_queue.sv */
`timescale 1ns / 1ps

module mndt_queue
  import mndt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  item_t   item_i,
  input  logic    pop_i,
  output item_t   item_o,
  output q_stat_t stat_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t            slot_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CntW'(QueueDepth));
  assign item_o       = slot_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // item storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* rtl/mndt_back.sv */
`timescale 1ns / 1ps

module mndt_back
  import mndt_pkg::*;
#(
  parameter int unsigned HELD_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             q_valid_i,
  input  item_t            q_item_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [KindW-1:0] result_kind_o,
  output logic [ClkW-1:0]  event_clock_o,
  output logic [KeyW-1:0]  note_key_o,
  output logic [DataW-1:0] data_value_o,
  output logic [TimeW-1:0] duration_o,
  output logic             track_mute_o
);

  localparam int unsigned AW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam int unsigned CW = $clog2(HELD_DEPTH + 1);
  localparam int unsigned EW = KeyW + TimeW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  item_t            cur_q, cur_d;
  logic [KindW-1:0] kind_q, kind_d;
  logic [TimeW-1:0] dur_q, dur_d;
  logic             mute_q, mute_d;
  logic             out_valid_q, out_valid_d;
  logic [KindW-1:0] o_kind_q, o_kind_d;
  logic [ClkW-1:0]  o_clock_q, o_clock_d;
  logic [KeyW-1:0]  o_key_q, o_key_d;
  logic [DataW-1:0] o_data_q, o_data_d;
  logic [TimeW-1:0] o_dur_q, o_dur_d;
  logic             o_mute_q, o_mute_d;

  // held-note stack memory, entry is {key, note-on time}
  logic [EW-1:0]    stack_mem [HELD_DEPTH];
  logic [EW-1:0]    rd_data_q;
  logic [AW-1:0]    rd_addr;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [EW-1:0]    mem_wdata;

  logic [KeyW-1:0]  rd_key;
  logic [TimeW-1:0] rd_time;
  logic             mute_next;

  assign rd_key  = rd_data_q[TimeW +: KeyW];
  assign rd_time = rd_data_q[TimeW-1:0];

  // sequencer: push, or search newest to oldest then close the gap
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    cur_d       = cur_q;
    kind_d      = kind_q;
    dur_d       = dur_q;
    mute_d      = mute_q;
    out_valid_d = out_valid_q && !out_ready_i;
    o_kind_d    = o_kind_q;
    o_clock_d   = o_clock_q;
    o_key_d     = o_key_q;
    o_data_d    = o_data_q;
    o_dur_d     = o_dur_q;
    o_mute_d    = o_mute_q;
    q_pop_o     = 1'b0;
    rd_addr     = ptr_q;
    mem_we      = 1'b0;
    mem_waddr   = count_q[AW-1:0];
    mem_wdata   = {q_item_i.key, q_item_i.now_time};
    mute_next   = mute_q;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_item_i;
          kind_d  = q_item_i.kind;
          dur_d   = '0;
          state_d = S_EMIT;
          case (q_item_i.op)
            OP_PUSH: begin
              if (count_q == CW'(HELD_DEPTH)) begin
                kind_d = KIND_FULL;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + 1'b1;
                kind_d  = KIND_HELD;
                if (!cfg_i.record_merge) begin
                  mute_d = 1'b1;
                end
              end
            end
            OP_POP: begin
              if (count_q != '0) begin
                ptr_d   = AW'(count_q - 1'b1);
                rd_addr = AW'(count_q - 1'b1);
                state_d = S_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end

      // rd_data_q holds the entry at ptr_q
      S_SEARCH: begin
        if (rd_key == cur_q.key) begin
          kind_d = KIND_MATCHED;
          dur_d  = (cur_q.now_time >= rd_time) ? cur_q.now_time - rd_time : '0;
          if (CW'(ptr_q) + CW'(1) < count_q) begin
            rd_addr = AW'(CW'(ptr_q) + CW'(1));
            state_d = S_SHIFT;
          end else begin
            count_d = count_q - 1'b1;
            state_d = S_EMIT;
          end
        end else if (ptr_q == '0) begin
          state_d = S_EMIT;
        end else begin
          ptr_d   = ptr_q - 1'b1;
          rd_addr = ptr_q - 1'b1;
        end
      end

      // ptr_q is the hole, rd_data_q the entry above it
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = rd_data_q;
        rd_addr   = AW'(CW'(ptr_q) + CW'(2));
        if (CW'(ptr_q) + CW'(2) < count_q) begin
          ptr_d = AW'(CW'(ptr_q) + CW'(1));
        end else begin
          count_d = count_q - 1'b1;
          state_d = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          if (cur_q.op == OP_POP && count_q == '0 && !cfg_i.punch_in_enable) begin
            mute_next = 1'b0;
          end
          mute_d      = mute_next;
          out_valid_d = 1'b1;
          o_kind_d    = kind_q;
          o_clock_d   = cur_q.event_clock;
          o_key_d     = cur_q.key;
          o_data_d    = cur_q.data_value;
          o_dur_d     = dur_q;
          o_mute_d    = mute_next;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      cur_q       <= '0;
      kind_q      <= '0;
      dur_q       <= '0;
      mute_q      <= 1'b0;
      out_valid_q <= 1'b0;
      o_kind_q    <= '0;
      o_clock_q   <= '0;
      o_key_q     <= '0;
      o_data_q    <= '0;
      o_dur_q     <= '0;
      o_mute_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      cur_q       <= cur_d;
      kind_q      <= kind_d;
      dur_q       <= dur_d;
      mute_q      <= mute_d;
      out_valid_q <= out_valid_d;
      o_kind_q    <= o_kind_d;
      o_clock_q   <= o_clock_d;
      o_key_q     <= o_key_d;
      o_data_q    <= o_data_d;
      o_dur_q     <= o_dur_d;
      o_mute_q    <= o_mute_d;
    end
  end

  // single write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= stack_mem[rd_addr];
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = o_kind_q;
  assign event_clock_o = o_clock_q;
  assign note_key_o    = o_key_q;
  assign data_value_o  = o_data_q;
  assign duration_o    = o_dur_q;
  assign track_mute_o  = o_mute_q;

endmodule

/* rtl/midi_note_duration_tracker.sv */
`timescale 1ns / 1ps
`include "midi_note_duration_tracker_defines.svh"

// MIDI note duration tracker: one result item for every message item. A front
// end classifies each message and computes its event clock and data value, a
// two-entry queue decouples it from the back end, which keeps the held-note
// stack in a memory with one write port and one registered read port. Outside
// percussion mode, a note-off reads one stack entry per cycle from newest to
// oldest until it finds the key, then moves one entry per cycle to close the
// gap. The input accepts while the queue has room and the result register
// holds a finished item until it is taken. Configuration writes are registered
// and belong between items.
module midi_note_duration_tracker
  import mndt_pkg::*;
#(
  parameter int unsigned HELD_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input messages
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [47:0]         s_axis_tdata,  // key, velocity, now_time, zero pad
  input  logic [ModeW-1:0]    s_axis_tuser,  // mode
  // results
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [87:0]         m_axis_tdata,  // event_clock, note_key, data_value,
                                             // duration, track_mute, zero pad
  output logic [KindW-1:0]    m_axis_tuser,  // result_kind
  // register writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t             cfg_q, cfg_d;
  q_stat_t          q_stat;
  logic             q_push;
  logic             q_pop;
  item_t            q_in;
  item_t            q_out;
  logic [ClkW-1:0]  event_clock;
  logic [KeyW-1:0]  note_key;
  logic [DataW-1:0] data_value;
  logic [TimeW-1:0] duration;
  logic             track_mute;

  // register file
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PERC_MODE:    cfg_d.perc_mode       = cfg_data_i[0];
        CFG_RECORD_MERGE: cfg_d.record_merge    = cfg_data_i[0];
        CFG_PUNCH_IN:     cfg_d.punch_in_enable = cfg_data_i[0];
        CFG_LOOP_ADJUST:  cfg_d.loop_adjust     = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mndt_front u_front (
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .mode_i     (s_axis_tuser),
    .key_i      (s_axis_tdata[6:0]),
    .velocity_i (s_axis_tdata[13:7]),
    .now_time_i (s_axis_tdata[44:14]),
    .cfg_i      (cfg_q),
    .q_stat_i   (q_stat),
    .push_o     (q_push),
    .item_o     (q_in)
  );

  mndt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_in),
    .pop_i  (q_pop),
    .item_o (q_out),
    .stat_o (q_stat)
  );

  mndt_back #(
    .HELD_DEPTH (HELD_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (!q_stat.empty),
    .q_item_i      (q_out),
    .q_pop_o       (q_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .result_kind_o (m_axis_tuser),
    .event_clock_o (event_clock),
    .note_key_o    (note_key),
    .data_value_o  (data_value),
    .duration_o    (duration),
    .track_mute_o  (track_mute)
  );

  // result packing
  assign m_axis_tdata = {3'b000, track_mute, duration, data_value, note_key, event_clock};

  // checks
  `MNDT_ASSERT_NXT(a_accept_fills_queue, s_axis_tvalid && s_axis_tready, !q_stat.empty, "accepted item did not reach the queue")
  `MNDT_ASSERT_IMP(a_dur_only_on_match, m_axis_tvalid && m_axis_tuser != KIND_MATCHED, m_axis_tdata[83:53] == '0, "nonzero duration without a match")
  `MNDT_ASSERT_IMP(a_kind_in_range, m_axis_tvalid, m_axis_tuser <= KIND_DRUM_OFF, "result kind out of range")

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import mndt_pkg::*;

  localparam int unsigned HeldDepth    = 16;
  localparam int          RandPerPhase = 184;
  localparam int          DrainCycles  = 40;
  localparam int          IdleLimit    = 5000;
  localparam int          LongHold     = 250;
  localparam logic [ModeW-1:0] MODE_OTHER    = 3'd5;
  localparam logic [ModeW-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [ModeW-1:0] MODE_SPARE_HI = 3'd7;

  // one midi message item as the sender offers it
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [KeyW-1:0]  key;
    logic [VelW-1:0]  vel;
    logic [TimeW-1:0] now_time;
  } midi_msg_t;

  // one result item of the tracker
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ClkW-1:0]  event_clock;
    logic [KeyW-1:0]  key;
    logic [DataW-1:0] data;
    logic [TimeW-1:0] duration;
    logic             mute;
  } note_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [47:0]         s_axis_tdata = '0;
  logic [ModeW-1:0]    s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [87:0]         m_axis_tdata;
  logic [KindW-1:0]    m_axis_tuser;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  midi_note_duration_tracker #(
    .HELD_DEPTH(HeldDepth)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // own copy of the held-note stack, mute flag and registers
  logic [KeyW-1:0]  stk_key [HeldDepth];
  logic [TimeW-1:0] stk_time[HeldDepth];
  int               stk_count  = 0;
  logic             mute_state = 1'b0;
  logic             drum_on    = 1'b0;
  logic             merge_on   = 1'b0;
  logic             punch_on   = 1'b0;
  logic [TimeW-1:0] loop_ofs   = '0;

  midi_msg_t    msg_q[$];
  note_result_t expected_results[$];
  logic [KeyW-1:0] gen_keys[$];
  logic [TimeW-1:0] gen_time = '0;

  midi_msg_t drv_msg;
  int send_gap      = 0;
  int rcv_gap       = 0;
  int msgs_accepted = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int phases_run    = 0;
  int idle_cycles   = 0;
  int kind_seen[8];

  // tracker behavior for one accepted message item
  function automatic note_result_t predict_note_result(midi_msg_t m);
    note_result_t r;
    int           idx;
    int           j;
    bit           found;
    r             = '0;
    r.key         = m.key;
    r.event_clock = {1'b0, m.now_time} - {1'b0, loop_ofs};
    if (m.mode == MODE_NOTE_ON && m.vel != '0) begin
      r.data = DataW'(m.vel);
      if (drum_on) begin
        r.kind = KIND_APPENDED;
      end else if (stk_count >= HeldDepth) begin
        r.kind = KIND_FULL;
      end else begin
        stk_key[stk_count]  = m.key;
        stk_time[stk_count] = m.now_time;
        stk_count++;
        r.kind = KIND_HELD;
        if (!merge_on) mute_state = 1'b1;
      end
    end else if (m.mode == MODE_NOTE_ON || m.mode == MODE_NOTE_OFF) begin
      r.data = DataW'(m.vel);
      if (drum_on) begin
        r.kind = KIND_DRUM_OFF;
      end else begin
        // newest to oldest search for the key
        found = 1'b0;
        idx   = stk_count - 1;
        while (idx >= 0 && !found) begin
          if (stk_key[idx] == m.key) found = 1'b1;
          else idx--;
        end
        if (found) begin
          r.duration = (m.now_time >= stk_time[idx]) ? m.now_time - stk_time[idx] : '0;
          for (j = idx; j < stk_count - 1; j++) begin
            stk_key[j]  = stk_key[j+1];
            stk_time[j] = stk_time[j+1];
          end
          stk_count--;
          r.kind = KIND_MATCHED;
        end else begin
          r.kind = KIND_UNMATCHED;
        end
        if (stk_count == 0 && !punch_on) mute_state = 1'b0;
      end
    end else if (m.mode == MODE_BEND) begin
      r.data = {m.vel, m.key};
    end else if (m.mode == MODE_TOUCH) begin
      r.data = DataW'(m.key);
    end else if (m.mode == MODE_CONTROL) begin
      r.data = DataW'(m.vel);
    end else begin
      r.data = '0;
    end
    r.mute = mute_state;
    return r;
  endfunction

  // driver: offers queued message items with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(predict_note_result(drv_msg));
        msgs_accepted++;
        send_gap = ((msgs_accepted % 128) < 32) ? 0 : $urandom_range(0, 3);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (msg_q.size() > 0) begin
          drv_msg = msg_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= drv_msg.mode;
          s_axis_tdata  <= {3'b000, drv_msg.now_time, drv_msg.vel, drv_msg.key};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on result %0d, %s: expected %0h, got %0h",
                 results_seen, name, exp_v, act_v);
    end
  endtask

  // monitor: takes result items, checks them, stalls at random
  always @(posedge clk_i) begin
    note_result_t exp_r;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result item %0d arrived with none expected", results_seen);
        end else begin
          exp_r = expected_results.pop_front();
          kind_seen[exp_r.kind]++;
          check_field("result_kind", 32'(exp_r.kind), 32'(m_axis_tuser));
          check_field("event_clock", exp_r.event_clock, m_axis_tdata[31:0]);
          check_field("note_key", 32'(exp_r.key), 32'(m_axis_tdata[38:32]));
          check_field("data_value", 32'(exp_r.data), 32'(m_axis_tdata[52:39]));
          check_field("duration", 32'(exp_r.duration), 32'(m_axis_tdata[83:53]));
          check_field("track_mute", 32'(exp_r.mute), 32'(m_axis_tdata[84]));
        end
        results_seen++;
        rcv_gap = ((results_seen % 128) >= 64 && (results_seen % 128) < 96) ? 0 :
                  $urandom_range(0, 3);
        // long back-pressure so the input side fills up
        if (results_seen == 300 || results_seen == 1000) rcv_gap = LongHold;
      end
      if (rcv_gap > 0) begin
        rcv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any item moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("no item moved for %0d cycles, %0d results outstanding",
                 idle_cycles, expected_results.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic add_msg(input logic [ModeW-1:0] mode, input logic [KeyW-1:0] key,
                         input logic [VelW-1:0] vel, input logic [TimeW-1:0] t);
    midi_msg_t m;
    m.mode     = mode;
    m.key      = key;
    m.vel      = vel;
    m.now_time = t;
    msg_q.push_back(m);
  endtask

  // mostly note-on/note-off traffic on recently held keys, some noise
  task automatic add_random_msgs(input int count, input int on_pct);
    int              r;
    int              pick;
    logic [KeyW-1:0] k;
    repeat (count) begin
      if ($urandom_range(0, 19) == 0) gen_time = TimeW'($urandom());
      else gen_time = gen_time + TimeW'($urandom_range(0, 3000));
      r = $urandom_range(0, 99);
      if (r < on_pct) begin
        k = KeyW'($urandom_range(0, 127));
        add_msg(MODE_NOTE_ON, k, VelW'($urandom_range(1, 127)), gen_time);
        gen_keys.push_back(k);
        if (gen_keys.size() > 24) void'(gen_keys.pop_front());
      end else if (r < 88) begin
        if (gen_keys.size() > 0 && $urandom_range(0, 9) < 8) begin
          pick = $urandom_range(0, gen_keys.size() - 1);
          k    = gen_keys[pick];
          gen_keys.delete(pick);
        end else begin
          k = KeyW'($urandom_range(0, 127));
        end
        if ($urandom_range(0, 1))
          add_msg(MODE_NOTE_OFF, k, VelW'($urandom_range(0, 127)), gen_time);
        else
          add_msg(MODE_NOTE_ON, k, '0, gen_time);
      end else begin
        add_msg(ModeW'($urandom_range(2, 7)), KeyW'($urandom_range(0, 127)),
                VelW'($urandom_range(0, 127)), gen_time);
      end
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_PERC_MODE:    drum_on  = val[0];
      CFG_RECORD_MERGE: merge_on = val[0];
      CFG_PUNCH_IN:     punch_on = val[0];
      CFG_LOOP_ADJUST:  loop_ofs = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic drum, input logic merge, input logic punch,
                            input logic [TimeW-1:0] loop_v);
    write_reg(CFG_PERC_MODE, CfgDataW'(drum));
    write_reg(CFG_RECORD_MERGE, CfgDataW'(merge));
    write_reg(CFG_PUNCH_IN, CfgDataW'(punch));
    write_reg(CFG_LOOP_ADJUST, loop_v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    phases_run++;
    @(negedge clk_i);
  endtask

  // all items offered, all results in, then the back end settles
  task automatic wait_drained();
    do @(negedge clk_i);
    while (msg_q.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    int i;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: data value modes, unmatched off, fill to full, zero-velocity off
    set_config(1'b0, 1'b0, 1'b0, 31'd1000);
    add_msg(MODE_BEND, 7'd127, 7'd127, 31'd5);
    add_msg(MODE_BEND, 7'd0, 7'd0, 31'd6);
    add_msg(MODE_TOUCH, 7'd85, 7'd42, 31'd7);
    add_msg(MODE_CONTROL, 7'd42, 7'd127, 31'd8);
    add_msg(MODE_OTHER, 7'd127, 7'd127, 31'd9);
    add_msg(MODE_SPARE_LO, 7'd85, 7'd85, 31'd9);
    add_msg(MODE_SPARE_HI, 7'd42, 7'd42, 31'd9);
    add_msg(MODE_NOTE_OFF, 7'd9, 7'd64, 31'd10);
    for (i = 0; i < HeldDepth; i++) begin
      add_msg(MODE_NOTE_ON,
              (i == 0) ? 7'd0 : (i == 1) ? 7'd127 : (i < 4) ? 7'd33 :
                KeyW'($urandom_range(0, 127)),
              (i == 0) ? 7'd127 : VelW'($urandom_range(1, 127)),
              (i == 1) ? 31'h7FFF_FFFF : TimeW'(100 + 10 * i));
    end
    add_msg(MODE_NOTE_ON, 7'd1, 7'd1, 31'd300);
    // off earlier than its on: duration clamps to zero
    add_msg(MODE_NOTE_ON, 7'd127, 7'd0, 31'd310);
    add_msg(MODE_NOTE_OFF, 7'd33, 7'd127, 31'd320);
    wait_drained();

    // random phases over the register settings
    set_config(1'b0, 1'b0, 1'b0, TimeW'($urandom()));
    add_random_msgs(RandPerPhase, 45);
    wait_drained();
    set_config(1'b0, 1'b1, 1'b0, 31'h7FFF_FFFF);
    add_random_msgs(RandPerPhase, 55);
    wait_drained();
    set_config(1'b0, 1'b0, 1'b1, 31'd0);
    add_random_msgs(RandPerPhase, 45);
    wait_drained();
    set_config(1'b1, 1'b0, 1'b0, TimeW'($urandom()));
    add_random_msgs(RandPerPhase, 45);
    wait_drained();
    set_config(1'b0, 1'b1, 1'b1, TimeW'($urandom()));
    add_random_msgs(RandPerPhase, 55);
    wait_drained();
    set_config(1'b0, 1'b0, 1'b0, 31'h7FFF_FFFF);
    add_random_msgs(RandPerPhase, 40);
    wait_drained();
    set_config(1'(($urandom())), 1'($urandom()), 1'($urandom()), TimeW'($urandom()));
    add_random_msgs(RandPerPhase, 50);
    wait_drained();

    $display("covered %0d message items and %0d results over %0d register settings",
             msgs_accepted, results_seen, phases_run);
    $display("kinds: appended %0d held %0d matched %0d unmatched %0d full %0d drum-off %0d",
             kind_seen[KIND_APPENDED], kind_seen[KIND_HELD], kind_seen[KIND_MATCHED],
             kind_seen[KIND_UNMATCHED], kind_seen[KIND_FULL], kind_seen[KIND_DRUM_OFF]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/mndt_pkg.sv
rtl/mndt_front.sv
rtl/mndt_queue.sv
rtl/mndt_back.sv
rtl/midi_note_duration_tracker.sv
tb/sv/tb.sv
